// ===== rtl/core/sha1md_pkg.sv =====
package sha1md_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = $clog2(QDEPTH);

  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned ROUNDS = 80;
  localparam int unsigned DIGEST_WORDS = 5;
  localparam int unsigned LEN_BYTES = 8;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
  } item_t;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam word_t H_INIT [DIGEST_WORDS] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  localparam word_t K_R0 = 32'h5a827999;
  localparam word_t K_R1 = 32'h6ed9eba1;
  localparam word_t K_R2 = 32'h8f1bbcdc;
  localparam word_t K_R3 = 32'hca62c1d6;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;

  // round function plus round constant
  function automatic word_t round_mix(logic [6:0] r, word_t b, word_t c, word_t d);
    word_t f;
    word_t k;
    if (r < 7'd20) begin
      f = ((c ^ d) & b) ^ d;
      k = K_R0;
    end else if (r < 7'd40) begin
      f = b ^ c ^ d;
      k = K_R1;
    end else if (r < 7'd60) begin
      f = (b & c) | (d & (b | c));
      k = K_R2;
    end else begin
      f = b ^ c ^ d;
      k = K_R3;
    end
    return f + k;
  endfunction

endpackage

// ===== rtl/core/sha1md_fifo.sv =====
module sha1md_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  input  sha1md_pkg::item_t   push_item,
  output logic                push_ready,
  input  logic                pop,
  output logic                pop_valid,
  output sha1md_pkg::item_t   pop_item
);
  import sha1md_pkg::*;

  item_t            mem_r [QDEPTH];
  logic [QAW-1:0]   wr_ptr_r;
  logic [QAW-1:0]   rd_ptr_r;
  logic [QAW:0]     count_r;
  logic             do_push;
  logic             do_pop;

  assign push_ready = count_r != (QAW+1)'(QDEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QAW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + (QAW+1)'(1);
        2'b01:   count_r <= count_r - (QAW+1)'(1);
        default: count_r <= count_r;
      endcase
    end
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QAW+1)'(QDEPTH))
    else $error("queue count out of range");
  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    QAW'(wr_ptr_r - rd_ptr_r) == count_r[QAW-1:0])
    else $error("queue pointers disagree with count");
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!push_ready && !do_pop) |=> !push_ready)
    else $error("queue left full without a pop");
`endif

endmodule

// ===== rtl/core/sha1md_core.sv =====
module sha1md_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                item_valid,
  input  sha1md_pkg::item_t   item,
  output logic                item_pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata,
  output logic                out_tlast
);
  import sha1md_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_PAD, S_ROUND, S_FOLD, S_EMIT} state_t;

  localparam logic [6:0] LAST_ROUND = 7'(ROUNDS - 1);
  localparam logic [2:0] LAST_WORD = 3'(DIGEST_WORDS - 1);
  localparam logic [3:0] LEN_DONE = 4'(LEN_BYTES);

  state_t     state_r, state_nxt;
  word_t      w_r [BLOCK_WORDS];
  word_t      w_nxt [BLOCK_WORDS];
  word_t      h_r [DIGEST_WORDS];
  word_t      h_nxt [DIGEST_WORDS];
  word_t      a_r, b_r, c_r, d_r, e_r;
  word_t      a_nxt, b_nxt, c_nxt, d_nxt, e_nxt;
  logic [5:0] fill_r, fill_nxt;
  logic [63:0] bits_r, bits_nxt;
  logic [63:0] len_r, len_nxt;
  logic       mark_r, mark_nxt;
  logic [3:0] len_cnt_r, len_cnt_nxt;
  logic [6:0] round_r, round_nxt;
  logic [2:0] emit_r, emit_nxt;
  logic       out_valid_r, out_valid_nxt;
  word_t      out_word_r, out_word_nxt;
  logic       out_last_r, out_last_nxt;
  logic       absorb_en;
  logic [7:0] absorb_byte;
  logic       out_load;
  word_t      sched_new;
  word_t      temp;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tlast  = out_last_r;
  assign out_load   = !out_valid_r || out_tready;

  assign sched_new = {w_r[13][30:0] ^ w_r[8][30:0] ^ w_r[2][30:0] ^ w_r[0][30:0],
                      w_r[13][31] ^ w_r[8][31] ^ w_r[2][31] ^ w_r[0][31]};
  assign temp = {a_r[26:0], a_r[31:27]} + e_r + w_r[0] + round_mix(round_r, b_r, c_r, d_r);

  always_comb begin
    state_nxt     = state_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    c_nxt         = c_r;
    d_nxt         = d_r;
    e_nxt         = e_r;
    fill_nxt      = fill_r;
    bits_nxt      = bits_r;
    len_nxt       = len_r;
    mark_nxt      = mark_r;
    len_cnt_nxt   = len_cnt_r;
    round_nxt     = round_r;
    emit_nxt      = emit_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_word_nxt  = out_word_r;
    out_last_nxt  = out_last_r;
    item_pop      = 1'b0;
    absorb_en     = 1'b0;
    absorb_byte   = '0;

    case (state_r)
      S_IDLE: begin
        if (item_valid) begin
          item_pop = 1'b1;
          if (item.kind == KIND_DATA) begin
            absorb_en   = 1'b1;
            absorb_byte = item.data_byte;
            bits_nxt    = bits_r + 64'd8;
          end else begin
            len_nxt     = bits_r;
            mark_nxt    = 1'b0;
            len_cnt_nxt = '0;
            state_nxt   = S_PAD;
          end
        end
      end
      S_PAD: begin
        absorb_en = 1'b1;
        if (!mark_r) begin
          absorb_byte = PAD_MARK;
          mark_nxt    = 1'b1;
        end else if (len_cnt_r == '0 && fill_r != LEN_OFFSET) begin
          absorb_byte = '0;
        end else begin
          absorb_byte = len_r[63:56];
          len_nxt     = {len_r[55:0], 8'h00};
          len_cnt_nxt = len_cnt_r + 4'd1;
        end
      end
      S_ROUND: begin
        a_nxt = temp;
        b_nxt = a_r;
        c_nxt = {b_r[1:0], b_r[31:2]};
        d_nxt = c_r;
        e_nxt = d_r;
        for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
          w_nxt[i] = w_r[i + 1];
        end
        w_nxt[BLOCK_WORDS - 1] = sched_new;
        round_nxt = round_r + 7'd1;
        if (round_r == LAST_ROUND) begin
          state_nxt = S_FOLD;
        end
      end
      S_FOLD: begin
        h_nxt[0] = h_r[0] + a_r;
        h_nxt[1] = h_r[1] + b_r;
        h_nxt[2] = h_r[2] + c_r;
        h_nxt[3] = h_r[3] + d_r;
        h_nxt[4] = h_r[4] + e_r;
        if (len_cnt_r == LEN_DONE) begin
          state_nxt = S_EMIT;
        end else if (mark_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = h_r[emit_r];
          out_last_nxt  = emit_r == LAST_WORD;
          emit_nxt      = emit_r + 3'd1;
          if (emit_r == LAST_WORD) begin
            h_nxt       = H_INIT;
            bits_nxt    = '0;
            mark_nxt    = 1'b0;
            len_cnt_nxt = '0;
            emit_nxt    = '0;
            state_nxt   = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // big-endian byte shift through the whole block
    if (absorb_en) begin
      for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
        w_nxt[i] = {w_r[i][23:0], w_r[i + 1][31:24]};
      end
      w_nxt[BLOCK_WORDS - 1] = {w_r[BLOCK_WORDS - 1][23:0], absorb_byte};
      fill_nxt = fill_r + 6'd1;
      if (fill_r == 6'd63) begin
        a_nxt     = h_r[0];
        b_nxt     = h_r[1];
        c_nxt     = h_r[2];
        d_nxt     = h_r[3];
        e_nxt     = h_r[4];
        round_nxt = '0;
        state_nxt = S_ROUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      h_r         <= H_INIT;
      fill_r      <= '0;
      bits_r      <= '0;
      mark_r      <= 1'b0;
      len_cnt_r   <= '0;
      round_r     <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      h_r         <= h_nxt;
      fill_r      <= fill_nxt;
      bits_r      <= bits_nxt;
      mark_r      <= mark_nxt;
      len_cnt_r   <= len_cnt_nxt;
      round_r     <= round_nxt;
      emit_r      <= emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
    w_r        <= w_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    c_r        <= c_nxt;
    d_r        <= d_nxt;
    e_r        <= e_nxt;
    len_r      <= len_nxt;
    out_word_r <= out_word_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef SYNTHESIS
  a_round_block_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_ROUND |-> fill_r == '0)
    else $error("compression running on a partial block");
  a_emit_after_pad: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> mark_r && len_cnt_r == LEN_DONE)
    else $error("digest emitted before padding finished");
  a_last_restores: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && emit_r == LAST_WORD && out_load) |=>
      (out_valid_r && out_tlast && bits_r == '0 && state_r == S_IDLE))
    else $error("final word did not restore initial state");
`endif

endmodule

// ===== rtl/core/sha1_message_digest.sv =====
// SHA-1 digest engine, byte-serial stream in, five digest words out.
// Input channel: one request per byte. in_tuser = 0 appends in_tdata to the
// message; in_tuser = 1 closes the message (in_tdata ignored) and starts
// padding and digest output.
// Output channel: five requests per finished message, word 0 first,
// out_tlast high on the fifth word.
// Input requests land in a four-entry queue, so the sender is only held off
// once the queue is full while the engine works.
// Block processing: every 64th byte starts the compression rounds and the
// fold, during which the engine takes no new byte from the queue.
// Finish: 9 to 72 padding bytes, one or two compressions, then
// one output word per cycle while the receiver keeps out_tready high.
// A stalled receiver holds the output register; the engine waits on it and
// the queue keeps taking input until full.
// Reset (rst_n low, synchronous) loads the initial hash words, clears the
// length count and empties the queue; after a digest the same state returns.
module sha1_message_digest (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic        out_tlast
);
  import sha1md_pkg::*;

  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  assign in_item.kind      = in_tuser;
  assign in_item.data_byte = in_tdata;

  sha1md_fifo u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_tvalid),
    .push_item  (in_item),
    .push_ready (in_tready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_item   (q_item)
  );

  sha1md_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (q_valid),
    .item       (q_item),
    .item_pop   (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== tb/sha1_digest_checker.sv =====
`timescale 1ns / 1ps

module sha1_digest_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] kind
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [31:0] digest_word
  input  logic        out_tlast,
  output int          mismatch_count,
  output int          words_pending
);
  import sha1md_pkg::*;

  typedef struct packed {
    word_t digest_word;
    logic  is_last;
  } digest_entry_t;

  digest_entry_t digest_due[$];

  word_t       hash_h [DIGEST_WORDS];
  word_t       msg_block [BLOCK_WORDS];
  logic [5:0]  fill_count;
  logic [63:0] bit_count;

  function automatic word_t rol(input word_t x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic clear_hash();
    for (int i = 0; i < DIGEST_WORDS; i++) hash_h[i] = H_INIT[i];
    for (int i = 0; i < BLOCK_WORDS; i++) msg_block[i] = '0;
    fill_count = '0;
    bit_count = '0;
  endtask

  task automatic fold_block();
    word_t sched [ROUNDS];
    word_t a, b, c, d, e, f, k, t;
    for (int r = 0; r < BLOCK_WORDS; r++) sched[r] = msg_block[r];
    for (int r = BLOCK_WORDS; r < ROUNDS; r++)
      sched[r] = rol(sched[r-3] ^ sched[r-8] ^ sched[r-14] ^ sched[r-16], 1);
    a = hash_h[0];
    b = hash_h[1];
    c = hash_h[2];
    d = hash_h[3];
    e = hash_h[4];
    for (int r = 0; r < ROUNDS; r++) begin
      if (r < 20) begin
        f = ((c ^ d) & b) ^ d;
        k = K_R0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = K_R1;
      end else if (r < 60) begin
        f = (b & c) | (d & (b | c));
        k = K_R2;
      end else begin
        f = b ^ c ^ d;
        k = K_R3;
      end
      t = rol(a, 5) + e + sched[r] + k + f;
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    hash_h[0] += a;
    hash_h[1] += b;
    hash_h[2] += c;
    hash_h[3] += d;
    hash_h[4] += e;
  endtask

  task automatic take_byte(input logic [7:0] v);
    msg_block[fill_count[5:2]] = {msg_block[fill_count[5:2]][23:0], v};
    fill_count = fill_count + 6'd1;
    if (fill_count == 6'd0) fold_block();
  endtask

  // padding, length, then queue the five digest words
  task automatic close_message();
    logic [63:0] msg_len;
    msg_len = bit_count;
    take_byte(PAD_MARK);
    while (fill_count != LEN_OFFSET) take_byte(8'h00);
    for (int i = 0; i < LEN_BYTES; i++) take_byte(msg_len[63 - 8*i -: 8]);
    for (int i = 0; i < DIGEST_WORDS; i++)
      digest_due.push_back('{digest_word: hash_h[i], is_last: (i == DIGEST_WORDS - 1)});
    clear_hash();
  endtask

  task automatic flag_mismatch(input string what, input word_t exp_v, input word_t act_v);
    if (mismatch_count < 10)
      $display("%0t ns: %s: expected %h, got %h", $time, what, exp_v, act_v);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    digest_entry_t due;
    if (!rst_n) begin
      clear_hash();
      digest_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (digest_due.size() == 0) begin
          flag_mismatch("digest word with none due", '0, out_tdata);
        end else begin
          due = digest_due.pop_front();
          if (out_tdata !== due.digest_word)
            flag_mismatch("digest word", due.digest_word, out_tdata);
          if (out_tlast !== due.is_last)
            flag_mismatch("tlast", {31'd0, due.is_last}, {31'd0, out_tlast});
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == KIND_FINISH) begin
          close_message();
        end else begin
          take_byte(in_tdata);
          bit_count = bit_count + 64'd8;
        end
      end
    end
    words_pending = digest_due.size();
  end

endmodule

// ===== tb/sha1_message_digest_test.sv =====
`timescale 1ns / 1ps

module sha1_message_digest_test;
  import sha1md_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic        out_tlast;
  logic [9:0]  stall_phase = '0;
  int          mismatch_count;
  int          words_pending;

  item_t byte_requests[$];

  sha1_message_digest DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  sha1_digest_checker checker_i (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .mismatch_count(mismatch_count),
    .words_pending (words_pending)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // receiver: always ready, random, sparse, then mostly ready
  always @(posedge clk) begin
    if (!rst_n) begin
      stall_phase <= '0;
      out_tready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 10'd1;
      case (stall_phase[9:8])
        2'd0: out_tready <= 1'b1;
        2'd1: out_tready <= ($urandom_range(0, 1) == 0);
        2'd2: out_tready <= (stall_phase[2:0] == 3'd5);
        default: out_tready <= (stall_phase[4:0] < 5'd19);
      endcase
    end
  end

  // fill: 0 random, 1 all zero, 2 all ones; finish carries a junk byte
  task automatic queue_message(input int n_bytes, input int fill);
    logic [7:0] v;
    for (int i = 0; i < n_bytes; i++) begin
      case (fill)
        1: v = 8'h00;
        2: v = 8'hff;
        default: v = 8'($urandom_range(0, 255));
      endcase
      byte_requests.push_back({KIND_DATA, v});
    end
    byte_requests.push_back({KIND_FINISH, 8'($urandom_range(0, 255))});
  endtask

  task automatic send_request(input item_t req);
    in_tvalid <= 1'b1;
    in_tuser <= req.kind;
    in_tdata <= req.data_byte;
    do @(posedge clk); while (!in_tready);
  endtask

  initial begin
    int idx;
    int burst;
    int gap;
    int msg_len;
    int fill;
    int edge_lens [10];
    edge_lens = '{0, 1, 55, 56, 57, 63, 64, 65, 119, 120};
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tuser <= KIND_DATA;
    in_tdata <= 8'h00;

    // empty messages, finish byte both extremes; then abc and three short messages
    byte_requests.push_back({KIND_FINISH, 8'hff});
    byte_requests.push_back({KIND_FINISH, 8'h00});
    byte_requests.push_back({KIND_DATA, 8'h61});
    byte_requests.push_back({KIND_DATA, 8'h62});
    byte_requests.push_back({KIND_DATA, 8'h63});
    byte_requests.push_back({KIND_FINISH, 8'h5a});
    queue_message(1, 2);
    queue_message(1, 1);
    queue_message(3, 0);

    while (byte_requests.size() < 330) begin
      case ($urandom_range(0, 9))
        0, 1, 2: msg_len = edge_lens[$urandom_range(0, 9)];
        3: msg_len = $urandom_range(66, 140);
        default: msg_len = $urandom_range(0, 54);
      endcase
      case ($urandom_range(0, 9))
        0: fill = 1;
        1: fill = 2;
        default: fill = 0;
      endcase
      queue_message(msg_len, fill);
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idx = 0;
    while (idx < byte_requests.size()) begin
      burst = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      for (int n = 0; n < burst && idx < byte_requests.size(); n++) begin
        send_request(byte_requests[idx]);
        idx++;
      end
      in_tvalid <= 1'b0;
      in_tdata <= 8'($urandom_range(0, 255));
      gap = $urandom_range(1, 8);
      repeat (gap) @(posedge clk);
    end

    while (words_pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (mismatch_count == 0 && words_pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
